@@ rtl/core/midpoint_ellipse_rasterizer_assert.svh @@
// assertion macros for the midpoint ellipse rasterizer checks
// expects clk and rst in the scope where a macro is used
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define MER_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("midpoint ellipse rasterizer check failed");

// next-cycle implication
`define MER_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("midpoint ellipse rasterizer check failed");

`endif

@@ rtl/core/mer_pkg.sv @@
// shared types and constants of the midpoint ellipse rasterizer
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package mer_pkg;

  // run length cap
  localparam int MAX_RESULTS = 64;

  // port field widths
  localparam int RX_W  = 5;
  localparam int RY_W  = 6;
  localparam int CFG_W = 6;
  localparam int CX_W  = 11;
  localparam int IN_W  = 24;
  localparam int CO_W  = 12;
  localparam int OUT_W = 48;

  // register reset values
  localparam logic [RX_W-1:0] RX_RESET = 5'd20;
  localparam logic [RY_W-1:0] RY_RESET = 6'd35;

  // register indexes
  localparam logic REG_RADIUS_X = 1'b0;
  localparam logic REG_RADIUS_Y = 1'b1;

  // decision values carry 2 fractional bits
  localparam int FRAC_SH = 2;

  // internal widths
  localparam int XY_W   = 8;
  localparam int D_W    = 22;
  localparam int P_W    = 32;
  localparam int RX2_W  = 10;
  localparam int RY2_W  = 12;
  localparam int RXRY_W = 16;
  localparam int TX_W   = 8;
  localparam int TY_W   = 9;
  localparam int A_W    = 15;
  localparam int B_W    = 13;
  localparam int M1_W   = 27;
  localparam int M2_W   = 23;
  localparam int M3_W   = 22;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic init1;
    logic step1;
    logic r2a;
    logic r2b;
    logic r2c;
    logic step2;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic cond1;
    logic more2;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/core/mer_dpath.sv @@
// datapath: radius registers, midpoint decision arithmetic, point outputs
// depends on mer_pkg; driven by commands from mer_ctrl
`timescale 1ns / 1ps
`default_nettype none

module mer_dpath #(
  parameter int MAX_RESULTS = mer_pkg::MAX_RESULTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [mer_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic [mer_pkg::IN_W-1:0]   in_data,
  input  wire mer_pkg::cmd_t              cmd,
  output mer_pkg::stat_t                  stat,
  output logic [mer_pkg::OUT_W-1:0]       out_data
);
  import mer_pkg::*;

  localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int TXSQ_W  = 2 * TX_W;
  localparam int TYSQ_W  = 2 * TY_W;

  // configuration registers
  logic [RX_W-1:0] radius_x;
  logic [RY_W-1:0] radius_y;

  // per-run state
  logic signed [CX_W-1:0] cx, cy;
  logic [RX2_W-1:0]       rx2;
  logic [RY2_W-1:0]       ry2;
  logic [RY_W-1:0]        ry_l;
  logic signed [XY_W-1:0] x, y;
  logic signed [D_W-1:0]  dx, dy;
  logic signed [P_W-1:0]  p;
  logic [CNT_W-1:0]       n;
  logic [A_W-1:0]         a;
  logic [B_W-1:0]         b;
  logic [M1_W-1:0]        m1;
  logic [M2_W-1:0]        m2;
  logic [M3_W-1:0]        m3;

  // combinational terms
  logic [RX2_W-1:0]        rx_sq;
  logic [RY2_W-1:0]        ry_sq;
  logic [RXRY_W-1:0]       rxry;
  logic signed [P_W-1:0]   rx2_p, ry2_p, rxry_p, p_init;
  logic signed [D_W-1:0]   rx2_d, ry2_d, dx_inc, dy_dec;
  logic signed [XY_W-1:0]  x_inc, y_dec;
  logic                    p_neg, p_pos;
  logic signed [XY_W-1:0]  s1_y, s2_x, nx, ny;
  logic signed [D_W-1:0]   s1_dy, s2_dx;
  logic signed [P_W-1:0]   s1_p, s2_p;
  logic [TX_W-1:0]         tx;
  logic [TXSQ_W-1:0]       tx_sq;
  logic signed [TY_W-1:0]  ty;
  logic signed [TYSQ_W-1:0] ty_sq;
  logic signed [CO_W-1:0]  x_r, x_l, y_t, y_b;
  logic                    n_full;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_x <= RX_RESET;
      radius_y <= RY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS_X: radius_x <= cfg_data[RX_W-1:0];
        REG_RADIUS_Y: radius_y <= cfg_data[RY_W-1:0];
        default: ;
      endcase
    end
  end

  // squares and products
  assign rx_sq  = RX2_W'(radius_x) * RX2_W'(radius_x);
  assign ry_sq  = RY2_W'(radius_y) * RY2_W'(radius_y);
  assign rxry   = RXRY_W'(rx2) * RXRY_W'(ry_l);
  assign rx2_p  = P_W'(rx2);
  assign ry2_p  = P_W'(ry2);
  assign rxry_p = P_W'(rxry);
  assign rx2_d  = D_W'(rx2);
  assign ry2_d  = D_W'(ry2);
  assign p_init = (ry2_p <<< FRAC_SH) - (rxry_p <<< FRAC_SH) + rx2_p;

  // shared increments
  assign x_inc  = x + XY_W'(1);
  assign y_dec  = y - XY_W'(1);
  assign dx_inc = dx + (ry2_d <<< 1);
  assign dy_dec = dy - (rx2_d <<< 1);
  assign p_neg  = p[P_W-1];
  assign p_pos  = !p_neg && (p != '0);

  // region 1 step
  always_comb begin
    if (p_neg) begin
      s1_y  = y;
      s1_dy = dy;
      s1_p  = p + ((P_W'(dx_inc) + ry2_p) <<< FRAC_SH);
    end else begin
      s1_y  = y_dec;
      s1_dy = dy_dec;
      s1_p  = p + ((P_W'(dx_inc) - P_W'(dy_dec) + ry2_p) <<< FRAC_SH);
    end
  end

  // region 2 step
  always_comb begin
    if (p_pos) begin
      s2_x  = x;
      s2_dx = dx;
      s2_p  = p + ((rx2_p - P_W'(dy_dec)) <<< FRAC_SH);
    end else begin
      s2_x  = x_inc;
      s2_dx = dx_inc;
      s2_p  = p + ((P_W'(dx_inc) - P_W'(dy_dec) + rx2_p) <<< FRAC_SH);
    end
  end

  // new point and its mirrored coordinates
  assign nx  = cmd.step1 ? x_inc : s2_x;
  assign ny  = cmd.step1 ? s1_y : y_dec;
  assign x_r = CO_W'(cx) + CO_W'(nx);
  assign x_l = CO_W'(cx) - CO_W'(nx);
  assign y_t = CO_W'(cy) + CO_W'(ny);
  assign y_b = CO_W'(cy) - CO_W'(ny);

  // region 2 start terms
  assign tx    = {x[TX_W-2:0], 1'b1};
  assign tx_sq = TXSQ_W'(tx) * TXSQ_W'(tx);
  assign ty    = TY_W'(y) - TY_W'(1);
  assign ty_sq = TYSQ_W'(ty) * TYSQ_W'(ty);

  // run registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx   <= in_data[CX_W-1:0];
      cy   <= in_data[2*CX_W-1:CX_W];
      rx2  <= rx_sq;
      ry2  <= ry_sq;
      ry_l <= radius_y;
      x    <= '0;
      y    <= XY_W'(radius_y);
      n    <= '0;
    end else if (cmd.init1) begin
      p  <= p_init;
      dx <= '0;
      dy <= D_W'({rxry, 1'b0});
    end else if (cmd.step1) begin
      x        <= x_inc;
      y        <= s1_y;
      dx       <= dx_inc;
      dy       <= s1_dy;
      p        <= s1_p;
      n        <= n + CNT_W'(1);
      out_data <= {y_b, y_t, x_l, x_r};
    end else if (cmd.r2a) begin
      a <= tx_sq[A_W-1:0];
      b <= ty_sq[B_W-1:0];
    end else if (cmd.r2b) begin
      m1 <= M1_W'(ry2) * M1_W'(a);
      m2 <= M2_W'(rx2) * M2_W'(b);
      m3 <= M3_W'(rx2) * M3_W'(ry2);
    end else if (cmd.r2c) begin
      p <= P_W'(m1) + (P_W'(m2) << FRAC_SH) - (P_W'(m3) << FRAC_SH);
    end else if (cmd.step2) begin
      x        <= s2_x;
      y        <= y_dec;
      dx       <= s2_dx;
      dy       <= dy_dec;
      p        <= s2_p;
      n        <= n + CNT_W'(1);
      out_data <= {y_b, y_t, x_l, x_r};
    end
  end

  // loop conditions
  assign n_full     = (n >= CNT_W'(MAX_RESULTS));
  assign stat.cond1 = !n_full && (dx <= dy);
  assign stat.more2 = !n_full && !y[XY_W-1] && (y != '0);

endmodule

`default_nettype wire

@@ rtl/core/mer_ctrl.sv @@
// controller: sequences the two regions and the result handshake
// depends on mer_pkg; commands mer_dpath
`timescale 1ns / 1ps
`default_nettype none

module mer_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                out_last,
  input  wire mer_pkg::stat_t stat,
  output mer_pkg::cmd_t       cmd
);
  import mer_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT1 = 4'd1;
  localparam logic [3:0] S_CHK1  = 4'd2;
  localparam logic [3:0] S_STEP1 = 4'd3;
  localparam logic [3:0] S_R2A   = 4'd4;
  localparam logic [3:0] S_R2B   = 4'd5;
  localparam logic [3:0] S_R2C   = 4'd6;
  localparam logic [3:0] S_CHK2  = 4'd7;
  localparam logic [3:0] S_STEP2 = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0] state, state_next;
  logic [3:0] ret, ret_next;
  logic       pend, pend_next;
  logic       last, last_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      pend  <= 1'b0;
      last  <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      pend  <= pend_next;
      last  <= last_next;
    end
  end

  // next state; a pending point goes out once it is known whether more follow
  always_comb begin
    state_next = state;
    ret_next   = ret;
    pend_next  = pend;
    last_next  = last;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_INIT1;
          pend_next  = 1'b0;
        end
      end
      S_INIT1: state_next = S_CHK1;
      S_CHK1: begin
        if (stat.cond1) begin
          if (pend) begin
            state_next = S_EMIT;
            ret_next   = S_STEP1;
            last_next  = 1'b0;
          end else begin
            state_next = S_STEP1;
          end
        end else begin
          state_next = S_R2A;
        end
      end
      S_STEP1: begin
        state_next = S_CHK1;
        pend_next  = 1'b1;
      end
      S_R2A: state_next = S_R2B;
      S_R2B: state_next = S_R2C;
      S_R2C: state_next = S_CHK2;
      S_CHK2: begin
        if (stat.more2) begin
          if (pend) begin
            state_next = S_EMIT;
            ret_next   = S_STEP2;
            last_next  = 1'b0;
          end else begin
            state_next = S_STEP2;
          end
        end else if (pend) begin
          state_next = S_EMIT;
          ret_next   = S_IDLE;
          last_next  = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_STEP2: begin
        state_next = S_CHK2;
        pend_next  = 1'b1;
      end
      S_EMIT: begin
        if (out_ready) begin
          state_next = ret;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // handshake and datapath commands
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign out_last  = last;
  assign cmd.load  = (state == S_IDLE) && in_valid;
  assign cmd.init1 = (state == S_INIT1);
  assign cmd.step1 = (state == S_STEP1);
  assign cmd.r2a   = (state == S_R2A);
  assign cmd.r2b   = (state == S_R2B);
  assign cmd.r2c   = (state == S_R2C);
  assign cmd.step2 = (state == S_STEP2);

endmodule

`default_nettype wire

@@ rtl/core/midpoint_ellipse_rasterizer.sv @@
// midpoint ellipse rasterizer top level: mer_ctrl plus mer_dpath, uses mer_pkg
// one request at a time; each point group is offered after the test that follows
// its step; each further group passes emit, step and test with m_tready high, and a
// run holds at most 64 groups, one step per point; region 2 start forms its
// products in states R2A, R2B, R2C; rst is synchronous, radii to 20/35
`timescale 1ns / 1ps
`default_nettype none

module midpoint_ellipse_rasterizer #(
  parameter int MAX_RESULTS = mer_pkg::MAX_RESULTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // config write: cfg_index 0 radius_x, 1 radius_y
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic                       cfg_index,
  input  wire logic [mer_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // [10:0] center_x, [21:11] center_y, [23:22] zero
  input  wire logic [mer_pkg::IN_W-1:0]   s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // [11:0] x_right, [23:12] x_left, [35:24] y_top, [47:36] y_bottom
  output logic [mer_pkg::OUT_W-1:0]       m_tdata,
  output logic                            m_tlast
);
  import mer_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // config writes always taken
  assign cfg_ready = 1'b1;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_last  (m_tlast),
    .stat      (stat),
    .cmd       (cmd)
  );

  mer_dpath #(
    .MAX_RESULTS (MAX_RESULTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/core/mer_checker.sv @@
// port-level checks of the midpoint ellipse rasterizer
// uses midpoint_ellipse_rasterizer_assert.svh; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none

`include "midpoint_ellipse_rasterizer_assert.svh"

module mer_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        m_tlast
);

  // no new request while a point group is offered
  `MER_ASSERT_IMP(a_busy_no_req, m_tvalid, !s_tready)

  // a run keeps going after a point group that is not the last
  `MER_ASSERT_NXT(a_mid_run, m_tvalid && m_tready && !m_tlast, !s_tready)

  // the last point group frees the block
  `MER_ASSERT_NXT(a_end_run, m_tvalid && m_tready && m_tlast, s_tready)

  // stalled point group holds
  `MER_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // mirrored pairs differ by an even amount
  `MER_ASSERT_IMP(a_mirror, m_tvalid, (m_tdata[0] == m_tdata[12]) && (m_tdata[24] == m_tdata[36]))

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
